/* rtl/core/tpp_pkg.sv */
// Shared widths, status codes, word layout, rounding, saturation and magnitude
// helpers for the tangent plane projection pipeline. No dependencies.
package tpp_pkg;

  localparam int IN_W            = 32;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int SUMW            = 67;
  localparam int RW              = SUMW - 30;
  localparam int DRW             = 36;
  localparam int XNW             = 36;

  localparam logic signed [IN_W-1:0] ONE_Q30  = IN_W'(32'sh4000_0000);
  localparam logic signed [IN_W-1:0] MONE_Q30 = -ONE_Q30;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_UNDEF = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [IN_W-1:0] sx;
    logic signed [IN_W-1:0] sy;
    logic signed [IN_W-1:0] sz;
    logic signed [IN_W-1:0] rx;
    logic signed [IN_W-1:0] ry;
    logic signed [IN_W-1:0] rz;
    logic                   pos;
    logic                   pole_p;
    logic                   pole_m;
    logic                   flag;
    logic signed [DRW-1:0]  dr;
    logic signed [IN_W-1:0] ex;
    logic signed [IN_W-1:0] ey;
    logic signed [XNW-1:0]  xn;
    logic signed [XNW-1:0]  yn;
  } item_t;

  typedef struct packed {
    logic neg;
    logic ovf;
    logic dz;
    logic nneg;
    logic nzero;
  } lane_t;

  function automatic logic signed [RW-1:0] round_q30(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] t;
    t = v + SUMW'(64'sh2000_0000);
    return RW'(t >>> 30);
  endfunction

  function automatic logic [IN_W:0] sat_in(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    hi = (RW'(1) <<< (IN_W - 1)) - RW'(1);
    lo = -(RW'(1) <<< (IN_W - 1));
    if (v > hi) begin
      return {1'b1, hi[IN_W-1:0]};
    end else if (v < lo) begin
      return {1'b1, lo[IN_W-1:0]};
    end
    return {1'b0, v[IN_W-1:0]};
  endfunction

  function automatic logic [IN_W-1:0] abs_in(input logic signed [IN_W-1:0] v);
    logic signed [IN_W:0] t;
    t = (IN_W+1)'(v);
    return IN_W'(t < 0 ? -t : t);
  endfunction

endpackage

/* rtl/core/tangent_plane_projection.sv */
// Top level of the gnomonic projector: products, dot sums, square root,
// eta/xi formation and final division. Uses tpp_pkg, tpp_sqrt, tpp_div, tpp_qsat.
//
//  channel | signals                                   | word
//  input   | in_valid, in_stall                        | star_x/y/z, centre_x/y/z
//  output  | out_valid, out_stall                      | plane_x, plane_y, status
//
// One word enters per cycle while in_stall is low. The root has 32 stages, the
// eta divider 32 stages and the final divider COORD_WIDTH stages. Reset clears
// valid bits only. A stalled output word sits in the output register while one
// more word lands in a skid register; in_stall rises only while that skid
// register is full.
module tangent_plane_projection #(
  parameter int COORD_WIDTH = tpp_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tpp_pkg::IN_W-1:0]     star_x,
  input  logic signed [tpp_pkg::IN_W-1:0]     star_y,
  input  logic signed [tpp_pkg::IN_W-1:0]     star_z,
  input  logic signed [tpp_pkg::IN_W-1:0]     centre_x,
  input  logic signed [tpp_pkg::IN_W-1:0]     centre_y,
  input  logic signed [tpp_pkg::IN_W-1:0]     centre_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_WIDTH-1:0]       plane_x,
  output logic signed [COORD_WIDTH-1:0]       plane_y,
  output logic        [1:0]                   status
);

  localparam int IN_W = tpp_pkg::IN_W;
  localparam int SUMW = tpp_pkg::SUMW;
  localparam int RW   = tpp_pkg::RW;
  localparam int DRW  = tpp_pkg::DRW;
  localparam int XNW  = tpp_pkg::XNW;
  localparam int PW   = 2 * IN_W;
  localparam int NW1  = PW;
  localparam int DVW1 = IN_W + 1;
  localparam int NW2  = XNW + 26;
  localparam int DVW2 = DRW + 1;
  localparam int CW   = COORD_WIDTH;
  localparam int ITW  = $bits(tpp_pkg::item_t);
  localparam int LNW  = $bits(tpp_pkg::lane_t);

  logic adv;
  logic skid_v;

  assign adv      = !skid_v;
  assign in_stall = skid_v;

  // products of s.r and rx^2, ry^2
  logic                 s1_v;
  tpp_pkg::item_t       s1_item;
  tpp_pkg::item_t       s1_item_next;
  logic signed [PW-1:0] s1_p0, s1_p1, s1_p2, s1_qx, s1_qy;

  always_comb begin
    s1_item_next    = '0;
    s1_item_next.sx = star_x;
    s1_item_next.sy = star_y;
    s1_item_next.sz = star_z;
    s1_item_next.rx = centre_x;
    s1_item_next.ry = centre_y;
    s1_item_next.rz = centre_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid;
    end
    if (adv) begin
      s1_item    <= s1_item_next;
      s1_p0      <= star_x * centre_x;
      s1_p1      <= star_y * centre_y;
      s1_p2      <= star_z * centre_z;
      s1_qx      <= centre_x * centre_x;
      s1_qy      <= centre_y * centre_y;
    end
  end

  // exact s.r, its sign and rounding, pole flags, radius squared
  logic signed [SUMW-1:0] dsum;
  logic                   s2_v;
  tpp_pkg::item_t         s2_item;
  tpp_pkg::item_t         s2_item_next;
  logic [PW-1:0]          s2_n2;

  assign dsum = SUMW'(s1_p0) + SUMW'(s1_p1) + SUMW'(s1_p2);

  always_comb begin
    s2_item_next        = s1_item;
    s2_item_next.pos    = dsum > 0;
    s2_item_next.dr     = DRW'(tpp_pkg::round_q30(dsum));
    s2_item_next.pole_p = s1_item.rz == tpp_pkg::ONE_Q30;
    s2_item_next.pole_m = s1_item.rz == tpp_pkg::MONE_Q30;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
    if (adv) begin
      s2_item        <= s2_item_next;
      s2_n2          <= $unsigned(s1_qx) + $unsigned(s1_qy);
    end
  end

  logic             sq_v;
  logic [IN_W-1:0]  sq_root;
  logic [ITW-1:0]   sq_side;
  tpp_pkg::item_t   sq_item;

  tpp_sqrt #(
    .RTW (IN_W),
    .SW  (ITW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_v     (s2_v),
    .in_rad   (s2_n2),
    .in_side  (s2_item),
    .out_v    (sq_v),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  assign sq_item = sq_side;

  // eta division setup
  logic [NW1-1:0]  d1x, d1y;
  logic [DVW1-1:0] v1;
  logic [NW1-1:0]  h1x, h1y;

  assign v1  = {sq_root, 1'b0};
  assign d1x = (NW1'(tpp_pkg::abs_in(sq_item.ry)) << 31) + NW1'(sq_root);
  assign d1y = (NW1'(tpp_pkg::abs_in(sq_item.rx)) << 31) + NW1'(sq_root);
  assign h1x = d1x >> IN_W;
  assign h1y = d1y >> IN_W;

  logic            s3_v;
  tpp_pkg::item_t  s3_item;
  tpp_pkg::lane_t  s3_lx, s3_ly;
  logic [DVW1-1:0] s3_remx, s3_remy, s3_dvs;
  logic [IN_W-1:0] s3_dlox, s3_dloy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= sq_v;
    end
    if (adv) begin
      s3_item        <= sq_item;
      s3_lx.neg      <= sq_item.ry > 0;
      s3_lx.nneg     <= sq_item.ry > 0;
      s3_lx.nzero    <= sq_item.ry == 0;
      s3_lx.dz       <= sq_root == '0;
      s3_lx.ovf      <= h1x >= NW1'(v1);
      s3_ly.neg      <= sq_item.rx < 0;
      s3_ly.nneg     <= sq_item.rx < 0;
      s3_ly.nzero    <= sq_item.rx == 0;
      s3_ly.dz       <= sq_root == '0;
      s3_ly.ovf      <= h1y >= NW1'(v1);
      s3_remx        <= DVW1'(h1x);
      s3_remy        <= DVW1'(h1y);
      s3_dlox        <= d1x[IN_W-1:0];
      s3_dloy        <= d1y[IN_W-1:0];
      s3_dvs         <= v1;
    end
  end

  logic                 ex_v, ey_v;
  logic [IN_W-1:0]      ex_q, ey_q;
  logic [ITW+LNW-1:0]   ex_side;
  logic [LNW-1:0]       ey_side;
  tpp_pkg::item_t       ex_item;
  tpp_pkg::lane_t       ex_lane, ey_lane;

  tpp_div #(
    .DVW (DVW1),
    .QW  (IN_W),
    .SW  (ITW + LNW)
  ) u_div_ex (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_v     (s3_v),
    .in_rem   (s3_remx),
    .in_dlo   (s3_dlox),
    .in_dvs   (s3_dvs),
    .in_side  ({s3_lx, s3_item}),
    .out_v    (ex_v),
    .out_q    (ex_q),
    .out_side (ex_side)
  );

  tpp_div #(
    .DVW (DVW1),
    .QW  (IN_W),
    .SW  (LNW)
  ) u_div_ey (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_v     (s3_v),
    .in_rem   (s3_remy),
    .in_dlo   (s3_dloy),
    .in_dvs   (s3_dvs),
    .in_side  (s3_ly),
    .out_v    (ey_v),
    .out_q    (ey_q),
    .out_side (ey_side)
  );

  assign {ex_lane, ex_item} = ex_side;
  assign ey_lane            = ey_side;

  logic signed [IN_W-1:0] ex_val, ey_val;
  logic                   ex_flag, ey_flag;

  tpp_qsat #(.QW(IN_W)) u_sat_ex (.q(ex_q), .lane(ex_lane), .val(ex_val), .flag(ex_flag));
  tpp_qsat #(.QW(IN_W)) u_sat_ey (.q(ey_q), .lane(ey_lane), .val(ey_val), .flag(ey_flag));

  logic           s4_v;
  tpp_pkg::item_t s4_item;
  tpp_pkg::item_t s4_item_next;

  always_comb begin
    s4_item_next      = ex_item;
    s4_item_next.ex   = ex_val;
    s4_item_next.ey   = ey_val;
    s4_item_next.flag = ex_flag || ey_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= ex_v && ey_v;
    end
    if (adv) begin
      s4_item      <= s4_item_next;
    end
  end

  // xi products
  logic                 s5_v;
  tpp_pkg::item_t       s5_item;
  logic signed [PW-1:0] s5_m1, s5_m2, s5_m3, s5_m4;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= s4_v;
    end
    if (adv) begin
      s5_item <= s4_item;
      s5_m1   <= s4_item.rz * s4_item.ey;
      s5_m2   <= s4_item.rz * s4_item.ex;
      s5_m3   <= s4_item.rx * s4_item.ey;
      s5_m4   <= s4_item.ry * s4_item.ex;
    end
  end

  // xi rounding and saturation
  logic [IN_W:0] xix_s, xiy_s, xiz_s;

  assign xix_s = tpp_pkg::sat_in(tpp_pkg::round_q30(-SUMW'(s5_m1)));
  assign xiy_s = tpp_pkg::sat_in(tpp_pkg::round_q30(SUMW'(s5_m2)));
  assign xiz_s = tpp_pkg::sat_in(tpp_pkg::round_q30(SUMW'(s5_m3) - SUMW'(s5_m4)));

  logic                   s6_v;
  tpp_pkg::item_t         s6_item;
  tpp_pkg::item_t         s6_item_next;
  logic signed [IN_W-1:0] s6_xix, s6_xiy, s6_xiz;

  always_comb begin
    s6_item_next      = s5_item;
    s6_item_next.flag = s5_item.flag || xix_s[IN_W] || xiy_s[IN_W] || xiz_s[IN_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (adv) begin
      s6_v <= s5_v;
    end
    if (adv) begin
      s6_item      <= s6_item_next;
      s6_xix       <= xix_s[IN_W-1:0];
      s6_xiy       <= xiy_s[IN_W-1:0];
      s6_xiz       <= xiz_s[IN_W-1:0];
    end
  end

  // numerator products
  logic                 s7_v;
  tpp_pkg::item_t       s7_item;
  logic signed [PW-1:0] s7_n1, s7_n2, s7_n3, s7_n4, s7_n5;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (adv) begin
      s7_v <= s6_v;
    end
    if (adv) begin
      s7_item <= s6_item;
      s7_n1   <= s6_item.sx * s6_xix;
      s7_n2   <= s6_item.sy * s6_xiy;
      s7_n3   <= s6_item.sz * s6_xiz;
      s7_n4   <= s6_item.sx * s6_item.ex;
      s7_n5   <= s6_item.sy * s6_item.ey;
    end
  end

  // numerators and divisor, pole cases picked here
  logic signed [RW-1:0] xg, yg;
  logic                 pole;

  assign xg   = tpp_pkg::round_q30(SUMW'(s7_n1) + SUMW'(s7_n2) + SUMW'(s7_n3));
  assign yg   = tpp_pkg::round_q30(SUMW'(s7_n4) + SUMW'(s7_n5));
  assign pole = s7_item.pole_p || s7_item.pole_m;

  logic                  s8_v;
  tpp_pkg::item_t        s8_item;
  tpp_pkg::item_t        s8_item_next;
  logic signed [DRW-1:0] s8_den;

  always_comb begin
    s8_item_next      = s7_item;
    s8_item_next.flag = pole ? 1'b0 : s7_item.flag;
    if (pole) begin
      s8_item_next.xn = XNW'(s7_item.sx);
      s8_item_next.yn = s7_item.pole_m ? -XNW'(s7_item.sy) : XNW'(s7_item.sy);
    end else begin
      s8_item_next.xn = XNW'(xg);
      s8_item_next.yn = XNW'(yg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (adv) begin
      s8_v <= s7_v;
    end
    if (adv) begin
      s8_item      <= s8_item_next;
      if (pole) begin
        s8_den     <= DRW'(s7_item.sz);
      end else begin
        s8_den     <= s7_item.dr;
      end
    end
  end

  // final division setup
  logic [XNW-1:0]    magx, magy;
  logic [DRW-1:0]    ud;
  logic [DVW2-1:0]   v2;
  logic [NW2+CW-1:0] d2x, d2y, h2x, h2y;

  assign magx = s8_item.xn < 0 ? XNW'(-s8_item.xn) : XNW'(s8_item.xn);
  assign magy = s8_item.yn < 0 ? XNW'(-s8_item.yn) : XNW'(s8_item.yn);
  assign ud   = s8_den < 0 ? DRW'(-s8_den) : DRW'(s8_den);
  assign v2   = {ud, 1'b0};
  assign d2x  = (NW2+CW)'((NW2'(magx) << 25) + NW2'(ud));
  assign d2y  = (NW2+CW)'((NW2'(magy) << 25) + NW2'(ud));
  assign h2x  = d2x >> CW;
  assign h2y  = d2y >> CW;

  logic            s9_v;
  tpp_pkg::item_t  s9_item;
  tpp_pkg::lane_t  s9_lx, s9_ly;
  logic [DVW2-1:0] s9_remx, s9_remy, s9_dvs;
  logic [CW-1:0]   s9_dlox, s9_dloy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (adv) begin
      s9_v <= s8_v;
    end
    if (adv) begin
      s9_item     <= s8_item;
      s9_lx.neg   <= (s8_item.xn < 0) != (s8_den < 0);
      s9_lx.nneg  <= s8_item.xn < 0;
      s9_lx.nzero <= s8_item.xn == 0;
      s9_lx.dz    <= s8_den == 0;
      s9_lx.ovf   <= h2x >= (NW2+CW)'(v2);
      s9_ly.neg   <= (s8_item.yn < 0) != (s8_den < 0);
      s9_ly.nneg  <= s8_item.yn < 0;
      s9_ly.nzero <= s8_item.yn == 0;
      s9_ly.dz    <= s8_den == 0;
      s9_ly.ovf   <= h2y >= (NW2+CW)'(v2);
      s9_remx     <= DVW2'(h2x);
      s9_remy     <= DVW2'(h2y);
      s9_dlox     <= d2x[CW-1:0];
      s9_dloy     <= d2y[CW-1:0];
      s9_dvs      <= v2;
    end
  end

  logic               px_v, py_v;
  logic [CW-1:0]      px_q, py_q;
  logic [ITW+LNW-1:0] px_side;
  logic [LNW-1:0]     py_side;
  tpp_pkg::item_t     px_item;
  tpp_pkg::lane_t     px_lane, py_lane;

  tpp_div #(
    .DVW (DVW2),
    .QW  (CW),
    .SW  (ITW + LNW)
  ) u_div_px (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_v     (s9_v),
    .in_rem   (s9_remx),
    .in_dlo   (s9_dlox),
    .in_dvs   (s9_dvs),
    .in_side  ({s9_lx, s9_item}),
    .out_v    (px_v),
    .out_q    (px_q),
    .out_side (px_side)
  );

  tpp_div #(
    .DVW (DVW2),
    .QW  (CW),
    .SW  (LNW)
  ) u_div_py (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_v     (s9_v),
    .in_rem   (s9_remy),
    .in_dlo   (s9_dloy),
    .in_dvs   (s9_dvs),
    .in_side  (s9_ly),
    .out_v    (py_v),
    .out_q    (py_q),
    .out_side (py_side)
  );

  assign {px_lane, px_item} = px_side;
  assign py_lane            = py_side;

  logic signed [CW-1:0] px_val, py_val;
  logic                 px_flag, py_flag;

  tpp_qsat #(.QW(CW)) u_sat_px (.q(px_q), .lane(px_lane), .val(px_val), .flag(px_flag));
  tpp_qsat #(.QW(CW)) u_sat_py (.q(py_q), .lane(py_lane), .val(py_val), .flag(py_flag));

  logic                 fv;
  logic signed [CW-1:0] fx, fy;
  logic [1:0]           fst;

  always_comb begin
    fv = px_v && py_v;
    if (!px_item.pos) begin
      fx  = '0;
      fy  = '0;
      fst = tpp_pkg::ST_UNDEF;
    end else begin
      fx  = px_val;
      fy  = py_val;
      fst = (px_item.flag || px_flag || py_flag) ? tpp_pkg::ST_SAT : tpp_pkg::ST_VALID;
    end
  end

  // output register with one skid word
  logic signed [CW-1:0] skid_x, skid_y;
  logic [1:0]           skid_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (!out_stall) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end
    end else if (!out_valid || !out_stall) begin
      out_valid <= fv;
    end else if (fv) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (!out_stall) begin
        plane_x <= skid_x;
        plane_y <= skid_y;
        status  <= skid_st;
      end
    end else if (!out_valid || !out_stall) begin
      plane_x <= fx;
      plane_y <= fy;
      status  <= fst;
    end else begin
      skid_x  <= fx;
      skid_y  <= fy;
      skid_st <= fst;
    end
  end

endmodule

/* rtl/core/tpp_sqrt.sv */
// Pipelined integer square root, one root bit per register stage.
// Carries a side word alongside; depends on nothing.
module tpp_sqrt #(
  parameter int RTW = 32,
  parameter int SW  = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_v,
  input  logic [2*RTW-1:0] in_rad,
  input  logic [SW-1:0]    in_side,
  output logic             out_v,
  output logic [RTW-1:0]   out_root,
  output logic [SW-1:0]    out_side
);

  localparam int REMW = RTW + 4;

  logic             v    [RTW];
  logic [REMW-1:0]  rem  [RTW];
  logic [RTW-1:0]   root [RTW];
  logic [2*RTW-1:0] rad  [RTW];
  logic [SW-1:0]    side [RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic             pv;
    logic [REMW-1:0]  prem;
    logic [RTW-1:0]   proot;
    logic [2*RTW-1:0] prad;
    logic [SW-1:0]    pside;
    logic [REMW-1:0]  t;
    logic [REMW-1:0]  trial;
    logic             take;

    if (k == 0) begin : g_first
      assign pv    = in_v;
      assign prem  = '0;
      assign proot = '0;
      assign prad  = in_rad;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v[k-1];
      assign prem  = rem[k-1];
      assign proot = root[k-1];
      assign prad  = rad[k-1];
      assign pside = side[k-1];
    end

    assign t     = {prem[RTW+1:0], prad[2*RTW-1:2*RTW-2]};
    assign trial = REMW'({proot, 2'b01});
    assign take  = t >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= pv;
      end
      if (adv) begin
        rem[k]  <= take ? t - trial : t;
        root[k] <= {proot[RTW-2:0], take};
        rad[k]  <= prad << 2;
        side[k] <= pside;
      end
    end
  end

  assign out_v    = v[RTW-1];
  assign out_root = root[RTW-1];
  assign out_side = side[RTW-1];

endmodule

/* rtl/core/tpp_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a side word alongside; depends on nothing.
module tpp_div #(
  parameter int DVW = 33,
  parameter int QW  = 32,
  parameter int SW  = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_v,
  input  logic [DVW-1:0] in_rem,
  input  logic [QW-1:0]  in_dlo,
  input  logic [DVW-1:0] in_dvs,
  input  logic [SW-1:0]  in_side,
  output logic           out_v,
  output logic [QW-1:0]  out_q,
  output logic [SW-1:0]  out_side
);

  logic           v    [QW];
  logic [DVW-1:0] rem  [QW];
  logic [QW-1:0]  dlo  [QW];
  logic [QW-1:0]  quo  [QW];
  logic [DVW-1:0] dvs  [QW];
  logic [SW-1:0]  side [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic           pv;
    logic [DVW-1:0] prem;
    logic [QW-1:0]  pdlo;
    logic [QW-1:0]  pquo;
    logic [DVW-1:0] pdvs;
    logic [SW-1:0]  pside;
    logic [DVW:0]   trial;
    logic           take;

    if (k == 0) begin : g_first
      assign pv    = in_v;
      assign prem  = in_rem;
      assign pdlo  = in_dlo;
      assign pquo  = '0;
      assign pdvs  = in_dvs;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v[k-1];
      assign prem  = rem[k-1];
      assign pdlo  = dlo[k-1];
      assign pquo  = quo[k-1];
      assign pdvs  = dvs[k-1];
      assign pside = side[k-1];
    end

    assign trial = {prem, pdlo[QW-1]};
    assign take  = trial >= {1'b0, pdvs};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= pv;
      end
      if (adv) begin
        rem[k]  <= take ? DVW'(trial - {1'b0, pdvs}) : DVW'(trial);
        dlo[k]  <= pdlo << 1;
        quo[k]  <= (pquo << 1) | QW'(take);
        dvs[k]  <= pdvs;
        side[k] <= pside;
      end
    end
  end

  assign out_v    = v[QW-1];
  assign out_q    = quo[QW-1];
  assign out_side = side[QW-1];

endmodule

/* rtl/core/tpp_qsat.sv */
// Sign, zero-divisor and saturation handling for one divider quotient.
// Uses tpp_pkg::lane_t.
module tpp_qsat #(
  parameter int QW = 32
) (
  input  logic                 [QW-1:0] q,
  input  tpp_pkg::lane_t                lane,
  output logic signed          [QW-1:0] val,
  output logic                          flag
);

  localparam logic [QW-1:0] MAXP = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] MINN = {1'b1, {(QW-1){1'b0}}};

  always_comb begin
    flag = 1'b0;
    val  = '0;
    priority if (lane.dz) begin
      flag = 1'b1;
      val  = lane.nzero ? '0 : (lane.nneg ? MINN : MAXP);
    end else if (lane.ovf) begin
      flag = 1'b1;
      val  = lane.neg ? MINN : MAXP;
    end else if (lane.neg) begin
      if (q > MINN) begin
        flag = 1'b1;
        val  = MINN;
      end else begin
        val = -q;
      end
    end else begin
      if (q[QW-1]) begin
        flag = 1'b1;
        val  = MAXP;
      end else begin
        val = q;
      end
    end
  end

endmodule

/* rtl/core/tpp_checker.sv */
// Port-level checks for tangent_plane_projection, bound to the top level.
// Uses tpp_pkg status codes.
module tpp_checker #(
  parameter int COORD_WIDTH = tpp_pkg::COORD_WIDTH_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic signed [tpp_pkg::IN_W-1:0] star_x,
  input logic signed [tpp_pkg::IN_W-1:0] star_y,
  input logic signed [tpp_pkg::IN_W-1:0] star_z,
  input logic signed [tpp_pkg::IN_W-1:0] centre_x,
  input logic signed [tpp_pkg::IN_W-1:0] centre_y,
  input logic signed [tpp_pkg::IN_W-1:0] centre_z,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [COORD_WIDTH-1:0]   plane_x,
  input logic signed [COORD_WIDTH-1:0]   plane_y,
  input logic        [1:0]               status
);

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tpp_pkg::ST_UNDEF |-> plane_x == 0 && plane_y == 0)
    else $error("undefined projection with nonzero coordinates");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no word held at output");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    in_stall && !out_stall |=> !in_stall)
    else $error("skid word not drained");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(plane_x) && $stable(plane_y)
      && $stable(status))
    else $error("stalled output word changed");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("handshake active after reset");

endmodule

bind tangent_plane_projection tpp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tpp_checker (.*);

/* test/tb_tangent_plane_projection.sv */
// Self-checking testbench for tangent_plane_projection: directed and random star/centre
// words, a bit-exact projection predictor, random idling and a long output hold-off.
// Depends on tpp_pkg and the tangent_plane_projection RTL.
module tb_tangent_plane_projection;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
  } star_word_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [1:0]         st;
  } plane_word_t;

  localparam int NUM_RANDOM = 1830;
  localparam int PHASE_LEN  = 470;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] star_x = '0, star_y = '0, star_z = '0;
  logic signed [31:0] centre_x = '0, centre_y = '0, centre_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] plane_x, plane_y;
  logic [1:0] status;

  star_word_t  pending_stars[$];
  plane_word_t expected_planes[$];
  int n_accepted = 0;
  int n_total = 0;
  int n_mismatch = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  tangent_plane_projection i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .star_x(star_x), .star_y(star_y), .star_z(star_z),
    .centre_x(centre_x), .centre_y(centre_y), .centre_z(centre_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .plane_x(plane_x), .plane_y(plane_y), .status(status)
  );

  function automatic wide_t round_q30_sum(input wide_t s);
    return (s + (wide_t'(1) <<< 29)) >>> 30;
  endfunction

  function automatic wide_t div_half_away(input wide_t num, input wide_t den,
                                          inout bit flag);
    wide_t un, ud, q;
    if (den == 0) begin
      flag = 1'b1;
      if (num > 0) return (wide_t'(1) <<< 63) - 1;
      if (num < 0) return -(wide_t'(1) <<< 63);
      return 0;
    end
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = (2 * un + ud) / (2 * ud);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic wide_t clamp(input wide_t v, input wide_t lo, input wide_t hi,
                                  inout bit flag);
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic wide_t floor_sqrt(input wide_t v);
    wide_t r, b;
    r = 0;
    b = wide_t'(1) <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic plane_word_t project_star(input star_word_t w);
    wide_t sx, sy, sz, rx, ry, rz, dot, dr, xn, yn, den, n, ex, ey, xix, xiy, xiz;
    wide_t one, qmax, qmin;
    bit flag;
    plane_word_t res;
    sx = w.sx; sy = w.sy; sz = w.sz;
    rx = w.rx; ry = w.ry; rz = w.rz;
    one = wide_t'(1) <<< 30;
    qmax = (wide_t'(1) <<< 31) - 1;
    qmin = -(wide_t'(1) <<< 31);
    flag = 1'b0;
    dot = sx * rx + sy * ry + sz * rz;
    if (dot <= 0) begin
      res.px = '0;
      res.py = '0;
      res.st = tpp_pkg::ST_UNDEF;
      return res;
    end
    dr = round_q30_sum(dot);
    if (rz == one) begin
      xn = sx; yn = sy; den = sz;
    end else if (rz == -one) begin
      xn = sx; yn = -sy; den = sz;
    end else begin
      n = floor_sqrt(rx * rx + ry * ry);
      ex = clamp(div_half_away(-ry * one, n, flag), qmin, qmax, flag);
      ey = clamp(div_half_away(rx * one, n, flag), qmin, qmax, flag);
      xix = clamp(round_q30_sum(-rz * ey), qmin, qmax, flag);
      xiy = clamp(round_q30_sum(rz * ex), qmin, qmax, flag);
      xiz = clamp(round_q30_sum(rx * ey - ry * ex), qmin, qmax, flag);
      xn = round_q30_sum(sx * xix + sy * xiy + sz * xiz);
      yn = round_q30_sum(sx * ex + sy * ey);
      den = dr;
    end
    res.px = 32'(clamp(div_half_away(xn * (wide_t'(1) <<< 24), den, flag), qmin, qmax,
                       flag));
    res.py = 32'(clamp(div_half_away(yn * (wide_t'(1) <<< 24), den, flag), qmin, qmax,
                       flag));
    res.st = flag ? tpp_pkg::ST_SAT : tpp_pkg::ST_VALID;
    return res;
  endfunction

  function automatic logic signed [31:0] to_q30(input real v);
    real t;
    t = v * 1073741824.0;
    if (t > 2147483647.0) t = 2147483647.0;
    if (t < -2147483648.0) t = -2147483648.0;
    return $rtoi(t);
  endfunction

  function automatic real rand_unit();
    return $urandom_range(0, 2000000) / 1000000.0 - 1.0;
  endfunction

  task automatic add_star(input logic signed [31:0] sx, sy, sz, rx, ry, rz);
    star_word_t w;
    w.sx = sx; w.sy = sy; w.sz = sz;
    w.rx = rx; w.ry = ry; w.rz = rz;
    pending_stars.push_back(w);
  endtask

  task automatic add_random_star();
    real ax, ay, az, bx, by, bz, m, spread;
    int kind;
    kind = $urandom_range(99);
    if (kind < 12) begin
      add_star($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      return;
    end
    ax = rand_unit(); ay = rand_unit(); az = rand_unit();
    m = $sqrt(ax * ax + ay * ay + az * az) + 1e-9;
    ax = ax / m; ay = ay / m; az = az / m;
    spread = (kind < 50) ? 0.05 : ((kind < 80) ? 0.5 : 2.0);
    bx = ax + spread * rand_unit();
    by = ay + spread * rand_unit();
    bz = az + spread * rand_unit();
    m = $sqrt(bx * bx + by * by + bz * bz) + 1e-9;
    bx = bx / m; by = by / m; bz = bz / m;
    if (kind < 20) begin
      add_star(to_q30(bx), to_q30(by), to_q30(bz), 0, 0,
               (kind < 16) ? tpp_pkg::ONE_Q30 : tpp_pkg::MONE_Q30);
    end else begin
      add_star(to_q30(bx), to_q30(by), to_q30(bz), to_q30(ax), to_q30(ay), to_q30(az));
    end
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    logic signed [31:0] hi, lo, one, mone;
    hi = 32'sh7fff_ffff;
    lo = 32'sh8000_0000;
    one = tpp_pkg::ONE_Q30;
    mone = tpp_pkg::MONE_Q30;
    add_star(0, 0, one, 0, 0, one);
    add_star(1000, -2000, one - 5, 0, 0, one);
    add_star(1000, 2000, -one + 9, 0, 0, mone);
    add_star(one, 0, 0, one, 0, 0);
    add_star(one, 0, 0, 0, one, 0);
    add_star(-one, 0, 0, one, 0, 0);
    add_star(one, 0, 0, one, 0, one);
    add_star(0, 0, one, 0, 0, one / 2);
    add_star(hi, hi, hi, hi, hi, hi);
    add_star(lo, lo, lo, lo, lo, lo);
    add_star(hi, lo, hi, lo, hi, lo);
    add_star(lo, lo, lo, hi, hi, hi);
    add_star(one, 0, 1, 0, 0, one);
    add_star(-one, hi, 1, 0, 0, mone);
    add_star(1, 0, 0, 1, 0, one / 2);
    add_star(one / 2, one / 2, one / 2, one / 2, one / 2,
             one / 2 + one / 4);
    add_star(hi, 0, 0, 1, 1, 0);
    add_star(lo, lo, 0, -1, -1, 0);
    for (int i = 0; i < NUM_RANDOM; i++) add_random_star();
    n_total = pending_stars.size();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (n_accepted < n_total || expected_planes.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    case ((n_accepted / PHASE_LEN) % 4)
      0: begin idle_pct <= 0;  stall_pct <= 0;  end
      1: begin idle_pct <= 53; stall_pct <= 0;  end
      2: begin idle_pct <= 0;  stall_pct <= 53; end
      default: begin idle_pct <= 34; stall_pct <= 34; end
    endcase
  end

  always @(posedge clk) begin
    star_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        w.sx = star_x; w.sy = star_y; w.sz = star_z;
        w.rx = centre_x; w.ry = centre_y; w.rz = centre_z;
        expected_planes.push_back(project_star(w));
        n_accepted <= n_accepted + 1;
      end
      if (pending_stars.size() != 0 && $urandom_range(99) >= idle_pct) begin
        w = pending_stars.pop_front();
        star_x <= w.sx; star_y <= w.sy; star_z <= w.sz;
        centre_x <= w.rx; centre_y <= w.ry; centre_z <= w.rz;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && n_accepted >= 200) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    plane_word_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_planes.size() == 0) begin
        n_mismatch <= n_mismatch + 1;
        if (n_mismatch < 10)
          $display("unexpected word: x=%0d y=%0d status=%0d", plane_x, plane_y, status);
      end else begin
        e = expected_planes.pop_front();
        if (plane_x !== e.px || plane_y !== e.py || status !== e.st) begin
          n_mismatch <= n_mismatch + 1;
          if (n_mismatch < 10)
            $display("mismatch: expected x=%0d y=%0d status=%0d, got x=%0d y=%0d status=%0d",
                     e.px, e.py, e.st, plane_x, plane_y, status);
        end
      end
    end
  end

endmodule

/* sim.f */
rtl/core/tpp_pkg.sv
rtl/core/tpp_sqrt.sv
rtl/core/tpp_div.sv
rtl/core/tpp_qsat.sv
rtl/core/tangent_plane_projection.sv
rtl/core/tpp_checker.sv
test/tb_tangent_plane_projection.sv
